@@ hdl/f2p_pkg.sv @@
package f2p_pkg;

    localparam int MantW   = 53;
    localparam int ProdW   = MantW + 15;
    localparam int RndW    = MantW + 2;
    localparam int ShW     = 6;
    localparam int ExpW    = 13;
    localparam int SampleW = 64;
    localparam int PcmW    = 16;

    localparam logic signed [PcmW-1:0] PcmPos = 16'sd32767;
    localparam logic signed [PcmW-1:0] PcmNeg = -16'sd32768;

    // smallest unbiased exponent still classed CLS_NORM; any exponent below it gives zero
    localparam logic signed [ExpW-1:0] MinExp = -13'sd24;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_NORM,
        CLS_POS_SAT,
        CLS_NEG_SAT
    } t_cls;

    typedef struct packed {
        t_cls                    cls;
        logic                    neg;
        logic                    dbl;
        logic signed [ShW-1:0]   uexp;
        logic [MantW-1:0]        mant;
    } t_dec;

endpackage

@@ hdl/float_to_pcm16_converter.sv @@
// Channel  | Signals                          | Payload
// s (in)   | i_s_tvalid o_s_tready i_s_tdata  | sample_bits[63:0]
// m (out)  | o_m_tvalid i_m_tready o_m_tdata  | pcm_sample[15:0]
// cfg      | i_cfg_valid o_cfg_ready i_cfg_data | source_is_double
//
// Decode and scale by 32767 (32768 if negative), round to source
// precision, shift and saturate. One word per cycle is accepted unless
// a full pipe stalls. Synchronous active-low reset clears valid bits
// and source_is_double. Each stage advances when the one after it is
// empty or advancing, so bubbles close up while the output word waits.
module float_to_pcm16_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] sample_bits
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] pcm_sample
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data   // [0] source_is_double
);

    logic r_dbl;

    f2p_pkg::t_dec dec;

    logic                          r_s1_v, r_s2_v, r_s3_v;
    f2p_pkg::t_dec                 r_s1_dec;
    logic [f2p_pkg::ProdW-1:0]     r_s1_prod;
    f2p_pkg::t_cls                 r_s2_cls;
    logic                          r_s2_neg;
    logic [f2p_pkg::RndW-1:0]      r_s2_rnd;
    logic [f2p_pkg::ShW-1:0]       r_s2_sh;
    logic [15:0]                   r_s2_nmag;
    logic [15:0]                   r_s3_pcm;

    logic                          rdy1, rdy2, rdy3;
    logic [f2p_pkg::ProdW-1:0]     n_s1_prod;
    logic [f2p_pkg::RndW-1:0]      n_s2_rnd;
    logic [f2p_pkg::ShW-1:0]       n_s2_sh;
    logic [15:0]                   n_s2_nmag;
    logic [15:0]                   n_s3_pcm;
    logic [f2p_pkg::MantW:0]       keep;
    logic                          gbit, sticky;
    logic [5:0]                    kdrop;
    logic signed [7:0]             sh_full;
    logic signed [7:0]             nsh_full;
    logic [f2p_pkg::MantW-1:0]     nsh_val;
    logic [f2p_pkg::RndW-1:0]      pint;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbl <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dbl <= i_cfg_data;
        end
    end

    assign rdy3       = !r_s3_v || i_m_tready;
    assign rdy2       = !r_s2_v || rdy3;
    assign rdy1       = !r_s1_v || rdy2;
    assign o_s_tready = rdy1;

    f2p_decode u_dec (
        .i_bits (i_s_tdata),
        .i_dbl  (r_dbl),
        .o_dec  (dec)
    );

    // times 32767 as one shift and subtract
    assign n_s1_prod = {dec.mant, 15'b0} - {15'b0, dec.mant};

    // round to source precision: drop 14 or 15 bits (double), 43 or 44 (single)
    always_comb begin
        case ({r_s1_dec.dbl, r_s1_prod[f2p_pkg::ProdW-1]})
            2'b10: begin
                kdrop  = 6'd14;
                keep   = r_s1_prod[67:14];
                gbit   = r_s1_prod[13];
                sticky = |r_s1_prod[12:0];
            end
            2'b11: begin
                kdrop  = 6'd15;
                keep   = {1'b0, r_s1_prod[67:15]};
                gbit   = r_s1_prod[14];
                sticky = |r_s1_prod[13:0];
            end
            2'b00: begin
                kdrop  = 6'd43;
                keep   = {29'b0, r_s1_prod[67:43]};
                gbit   = r_s1_prod[42];
                sticky = |r_s1_prod[41:0];
            end
            default: begin
                kdrop  = 6'd44;
                keep   = {30'b0, r_s1_prod[67:44]};
                gbit   = r_s1_prod[43];
                sticky = |r_s1_prod[42:0];
            end
        endcase
        n_s2_rnd  = {1'b0, keep} + {{(f2p_pkg::RndW-1){1'b0}}, gbit & (sticky | keep[0])};
        sh_full   = 8'sd52 - $signed({2'b00, kdrop}) - 8'(r_s1_dec.uexp);
        n_s2_sh   = sh_full[f2p_pkg::ShW-1:0];
        nsh_full  = 8'sd37 - 8'(r_s1_dec.uexp);
        nsh_val   = r_s1_dec.mant >> nsh_full[f2p_pkg::ShW-1:0];
        n_s2_nmag = nsh_val[15:0];
    end

    always_comb begin
        pint = r_s2_rnd >> r_s2_sh;
        case (r_s2_cls)
            f2p_pkg::CLS_POS_SAT: n_s3_pcm = f2p_pkg::PcmPos;
            f2p_pkg::CLS_NEG_SAT: n_s3_pcm = f2p_pkg::PcmNeg;
            f2p_pkg::CLS_NORM: begin
                if (r_s2_neg) begin
                    n_s3_pcm = 16'd0 - r_s2_nmag;
                end else if (|pint[f2p_pkg::RndW-1:15]) begin
                    n_s3_pcm = f2p_pkg::PcmPos;
                end else begin
                    n_s3_pcm = {1'b0, pint[14:0]};
                end
            end
            default: n_s3_pcm = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (rdy1) r_s1_v <= i_s_tvalid;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_dec  <= dec;
            r_s1_prod <= n_s1_prod;
        end
        if (rdy2) begin
            r_s2_cls  <= r_s1_dec.cls;
            r_s2_neg  <= r_s1_dec.neg;
            r_s2_rnd  <= n_s2_rnd;
            r_s2_sh   <= n_s2_sh;
            r_s2_nmag <= n_s2_nmag;
        end
        if (rdy3) begin
            r_s3_pcm <= n_s3_pcm;
        end
    end

    assign o_m_tvalid = r_s3_v;
    assign o_m_tdata  = r_s3_pcm;

endmodule

@@ hdl/f2p_decode.sv @@
module f2p_decode (
    input  logic [f2p_pkg::SampleW-1:0] i_bits,
    input  logic                        i_dbl,
    output f2p_pkg::t_dec               o_dec
);

    logic [10:0]                     exp_f;
    logic                            exp_max;
    logic                            frac_nz;
    logic signed [f2p_pkg::ExpW-1:0] uexp;

    always_comb begin
        if (i_dbl) begin
            exp_f   = i_bits[62:52];
            exp_max = &i_bits[62:52];
            frac_nz = |i_bits[51:0];
            uexp    = $signed({2'b00, i_bits[62:52]}) - 13'sd1023;
            o_dec.mant = {1'b1, i_bits[51:0]};
            o_dec.neg  = i_bits[63];
        end else begin
            exp_f   = {3'b000, i_bits[30:23]};
            exp_max = &i_bits[30:23];
            frac_nz = |i_bits[22:0];
            uexp    = $signed({5'b00000, i_bits[30:23]}) - 13'sd127;
            o_dec.mant = {1'b1, i_bits[22:0], 29'b0};
            o_dec.neg  = i_bits[31];
        end
        o_dec.dbl  = i_dbl;
        o_dec.uexp = uexp[f2p_pkg::ShW-1:0];

        if (exp_max && frac_nz) begin
            o_dec.cls = f2p_pkg::CLS_ZERO;
        end else if (exp_f == 11'd0) begin
            o_dec.cls = f2p_pkg::CLS_ZERO;
        end else if (uexp >= 13'sd0) begin
            // magnitude at least one, infinities included
            o_dec.cls = o_dec.neg ? f2p_pkg::CLS_NEG_SAT : f2p_pkg::CLS_POS_SAT;
        end else if (uexp < f2p_pkg::MinExp) begin
            o_dec.cls = f2p_pkg::CLS_ZERO;
        end else begin
            o_dec.cls = f2p_pkg::CLS_NORM;
        end
    end

endmodule

@@ hdl/f2p_checker.sv @@
module f2p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_cfg_ready
);

    // an empty or draining output lets the whole pipe advance
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind float_to_pcm16_converter f2p_checker u_f2p_checker (.*);

@@ sim/tb_float_to_pcm16_converter.sv @@
module tb_float_to_pcm16_converter;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;   // [63:0] sample_bits
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [15:0] pcm_sample
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0; // [0] source_is_double

    logic signed [f2p_pkg::PcmW-1:0] pcm_expected_q[$];
    bit     double_mode = 1'b0;
    bit     no_gaps = 1'b0;
    int     mismatches = 0;
    int     ready_hold = 0;

    float_to_pcm16_converter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    // truncate toward zero, then saturate
    function automatic logic signed [f2p_pkg::PcmW-1:0] clamp_pcm(real p);
        if (p >= 32767.0) return f2p_pkg::PcmPos;
        if (p <= -32768.0) return f2p_pkg::PcmNeg;
        return f2p_pkg::PcmW'($rtoi(p));
    endfunction

    function automatic logic signed [f2p_pkg::PcmW-1:0] pcm_from_single(logic [31:0] f);
        logic [7:0]  e;
        logic [63:0] pb;
        real         prod;
        e = f[30:23];
        if (e == 8'hFF) begin
            return (f[22:0] != 0) ? '0 : (f[31] ? f2p_pkg::PcmNeg : f2p_pkg::PcmPos);
        end
        // zero and subnormals scale to far below one
        if (e == 8'h00) return '0;
        pb = {f[31], 11'(e) + 11'd896, f[22:0], 29'b0};
        prod = f[31] ? $bitstoreal(pb) * 32768.0 : $bitstoreal(pb) * 32767.0;
        // round the exact product to single precision, nearest-even
        pb = $realtobits(prod);
        if (pb[28] && ((|pb[27:0]) || pb[29])) pb = pb + 64'h2000_0000;
        pb[28:0] = '0;
        return clamp_pcm($bitstoreal(pb));
    endfunction

    function automatic logic signed [f2p_pkg::PcmW-1:0] pcm_from_double(logic [63:0] b);
        real x;
        if (b[62:52] == 11'h7FF) begin
            return (b[51:0] != 0) ? '0 : (b[63] ? f2p_pkg::PcmNeg : f2p_pkg::PcmPos);
        end
        x = $bitstoreal(b);
        return clamp_pcm(x < 0.0 ? x * 32768.0 : x * 32767.0);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pcm_expected_q.size() == 0) begin
                    $display("%0t: unexpected word, actual %0d", $time, $signed(o_m_tdata));
                    mismatches++;
                end else begin
                    logic signed [f2p_pkg::PcmW-1:0] want;
                    want = pcm_expected_q.pop_front();
                    if (want !== o_m_tdata) begin
                        $display("%0t: pcm_sample mismatch, expected %0d, actual %0d",
                                 $time, want, $signed(o_m_tdata));
                        mismatches++;
                    end
                end
                ready_hold = no_gaps ? 0 : $urandom_range(0, 5);
                i_m_tready <= (ready_hold == 0);
            end else if (ready_hold > 0) begin
                ready_hold--;
                i_m_tready <= (ready_hold == 0);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(logic [63:0] bits);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= bits;
        do @(posedge i_clk); while (!o_s_tready);
        pcm_expected_q.push_back(double_mode ? pcm_from_double(bits)
                                             : pcm_from_single(bits[31:0]));
    endtask

    task automatic write_format(bit dbl);
        i_s_tvalid <= 1'b0;
        while (pcm_expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dbl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        double_mode = dbl;
    endtask

    task automatic test_single_edges();
        logic [63:0] v[17];
        v = '{64'h0, 64'h8000_0000, 64'h3F80_0000, 64'hBF80_0000, 64'h7F80_0000,
              64'hFF80_0000, 64'h7FC0_0000, 64'hFFFF_FFFF, 64'h0000_0001,
              64'h8000_0001, 64'h7F7F_FFFF, 64'hFF7F_FFFF, 64'h3F00_0000,
              64'h3F7F_FFFF, 64'hBF7F_FFFF, 64'hFFFF_FFFF_3F80_0000,
              64'hA5A5_5A5A_0000_0000};
        foreach (v[i]) send_sample(v[i]);
    endtask

    task automatic test_double_edges();
        logic [63:0] v[15];
        v = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
              64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
              64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
              64'h8000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
              64'h3FE0_0000_0000_0000, 64'hBFEF_FFFF_FFFF_FFFF,
              64'h3FEF_FFFF_FFFF_FFFF, 64'h0000_0000_3F80_0000};
        foreach (v[i]) send_sample(v[i]);
    endtask

    // mostly audio-range samples, some raw patterns
    task automatic test_random(int count);
        logic [63:0] b;
        for (int n = 0; n < count; n++) begin
            no_gaps = (n % 100) >= 80;
            b = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) begin
                if (double_mode) b[62:52] = 11'($urandom_range(1000, 1024));
                else b[30:23] = 8'($urandom_range(100, 128));
            end
            send_sample(b);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_format(1'b0);
        test_single_edges();
        write_format(1'b1);
        test_double_edges();
        test_random(250);
        write_format(1'b0);
        test_random(250);
        write_format(1'b1);
        test_random(100);
        write_format(1'b0);
        test_random(60);
        i_s_tvalid <= 1'b0;
        while (pcm_expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
